/* rtl/core/max_heap_priority_queue_defines.svh */
// Assertion macros shared by the heap queue RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// A condition that must hold at every clock edge outside reset.
`define MHPQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("mhpq assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhpq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhpq assertion failed");

`else

`define MHPQ_ASSERT(label, cond)
`define MHPQ_ASSERT_IMP(label, ante, cons)
`define MHPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/mhpq_pkg.sv */
package mhpq_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  // Counts and child indexes need one bit more than a store address.
  localparam int KW       = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int ENT_W    = 6;
  localparam int STAT_W   = 2;
  localparam int OUT_W    = DATA_W + ENT_W + STAT_W;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_SORT    = 2'd2,
    OP_REBUILD = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [ENT_W-1:0]         entries;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage

/* rtl/core/mhpq_engine.sv */
`include "max_heap_priority_queue_defines.svh"

module mhpq_engine import mhpq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    idle,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_INS_CHK   = 16'h0002,
    S_INS_CMP   = 16'h0004,
    S_DEL_LD    = 16'h0008,
    S_HEAP_NEXT = 16'h0010,
    S_HEAP_LD   = 16'h0020,
    S_SD_RDL    = 16'h0040,
    S_SD_RDR    = 16'h0080,
    S_SD_CMP    = 16'h0100,
    S_SRT_NEXT  = 16'h0200,
    S_SRT_RDN   = 16'h0400,
    S_SRT_SWP   = 16'h0800,
    S_EMIT_RD   = 16'h1000,
    S_EMIT_OUT  = 16'h2000,
    S_MAX_RD    = 16'h4000,
    S_MAX_OUT   = 16'h8000
  } state_t;

  // Where a sift-down goes once the moving element has settled.
  typedef enum logic [1:0] {
    RET_MAX  = 2'd0,
    RET_HEAP = 2'd1,
    RET_SORT = 2'd2
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;
  op_t    op, op_next;
  status_t stat, stat_next;

  logic [KW-1:0]    cnt, cnt_next;
  logic [KW-1:0]    nlim, nlim_next;
  logic [KW-1:0]    hidx, hidx_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic signed [DATA_W-1:0] lval, lval_next;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;
  logic                     rd_en, wr_en;
  logic [IDX_W-1:0]         rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic [KW-1:0]    lchild, rchild, cnt_m1, nlim_m1, hidx_m1, hidx_p1;
  logic [IDX_W-1:0] pos_m1, parent;
  logic             r_ok, take_l, take_r;
  logic signed [DATA_W-1:0] big_lc;
  state_t           ret_state;

  assign lchild  = {pos, 1'b1};
  assign rchild  = lchild + 1'b1;
  assign r_ok    = rchild < nlim;
  assign cnt_m1  = cnt - 1'b1;
  assign nlim_m1 = nlim - 1'b1;
  assign hidx_m1 = hidx - 1'b1;
  assign hidx_p1 = hidx + 1'b1;
  assign pos_m1  = pos - 1'b1;
  assign parent  = pos_m1 >> 1;

  assign take_l  = cur < lval;
  assign big_lc  = take_l ? lval : cur;
  assign take_r  = r_ok && (big_lc < rdata);

  always_comb begin
    unique case (ret)
      RET_HEAP: ret_state = S_HEAP_NEXT;
      RET_SORT: ret_state = S_SRT_NEXT;
      RET_MAX:  ret_state = S_MAX_RD;
      default:  ret_state = S_MAX_RD;
    endcase
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    op_next    = op;
    stat_next  = stat;
    cnt_next   = cnt;
    nlim_next  = nlim;
    hidx_next  = hidx;
    pos_next   = pos;
    cur_next   = cur;
    lval_next  = lval;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = cur;
    res_valid  = 1'b0;
    res        = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next   = req.op;
          stat_next = STAT_OK;
          unique case (req.op)
            OP_INSERT: begin
              if (cnt == KW'(CAPACITY)) begin
                stat_next  = STAT_FULL;
                state_next = S_MAX_RD;
              end else begin
                pos_next   = cnt[IDX_W-1:0];
                cur_next   = req.value;
                cnt_next   = cnt + 1'b1;
                state_next = S_INS_CHK;
              end
            end
            OP_DELETE: begin
              if (cnt == '0) begin
                stat_next  = STAT_EMPTY;
                state_next = S_MAX_RD;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cnt_m1[IDX_W-1:0];
                cnt_next   = cnt_m1;
                state_next = S_DEL_LD;
              end
            end
            OP_SORT, OP_REBUILD: begin
              if (cnt == '0) begin
                if (req.op == OP_SORT) begin
                  stat_next = STAT_EMPTY;
                end
                state_next = S_MAX_RD;
              end else begin
                hidx_next  = cnt >> 1;
                nlim_next  = cnt;
                state_next = S_HEAP_NEXT;
              end
            end
          endcase
        end
      end
      S_INS_CHK: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = S_MAX_RD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = parent;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rdata < cur) begin
          // Parent moves down into the hole; keep climbing.
          wr_data    = rdata;
          pos_next   = parent;
          state_next = S_INS_CHK;
        end else begin
          state_next = S_MAX_RD;
        end
      end
      S_DEL_LD: begin
        cur_next   = rdata;
        pos_next   = '0;
        nlim_next  = cnt;
        ret_next   = RET_MAX;
        state_next = S_SD_RDL;
      end
      S_HEAP_NEXT: begin
        if (hidx == '0) begin
          if (op == OP_SORT) begin
            state_next = S_SRT_NEXT;
          end else begin
            state_next = S_MAX_RD;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = hidx_m1[IDX_W-1:0];
          pos_next   = hidx_m1[IDX_W-1:0];
          hidx_next  = hidx_m1;
          state_next = S_HEAP_LD;
        end
      end
      S_HEAP_LD: begin
        cur_next   = rdata;
        ret_next   = RET_HEAP;
        state_next = S_SD_RDL;
      end
      S_SD_RDL: begin
        if (lchild < nlim) begin
          rd_en      = 1'b1;
          rd_addr    = lchild[IDX_W-1:0];
          state_next = S_SD_RDR;
        end else begin
          wr_en      = 1'b1;
          state_next = ret_state;
        end
      end
      S_SD_RDR: begin
        lval_next = rdata;
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = rchild[IDX_W-1:0];
        end
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data    = rdata;
          pos_next   = rchild[IDX_W-1:0];
          state_next = S_SD_RDL;
        end else if (take_l) begin
          wr_data    = lval;
          pos_next   = lchild[IDX_W-1:0];
          state_next = S_SD_RDL;
        end else begin
          state_next = ret_state;
        end
      end
      S_SRT_NEXT: begin
        if (nlim <= KW'(1)) begin
          hidx_next  = '0;
          state_next = S_EMIT_RD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = S_SRT_RDN;
        end
      end
      S_SRT_RDN: begin
        lval_next  = rdata;
        rd_en      = 1'b1;
        rd_addr    = nlim_m1[IDX_W-1:0];
        state_next = S_SRT_SWP;
      end
      S_SRT_SWP: begin
        // Root goes to the tail; the old tail sifts down from the root.
        wr_en      = 1'b1;
        wr_addr    = nlim_m1[IDX_W-1:0];
        wr_data    = lval;
        cur_next   = rdata;
        nlim_next  = nlim_m1;
        pos_next   = '0;
        ret_next   = RET_SORT;
        state_next = S_SD_RDL;
      end
      S_EMIT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = hidx[IDX_W-1:0];
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        res_valid   = 1'b1;
        res.element = rdata;
        res.entries = ENT_W'(cnt);
        res.status  = stat;
        res.last    = (hidx_p1 == cnt);
        if (res_ready) begin
          if (hidx_p1 == cnt) begin
            state_next = S_IDLE;
          end else begin
            hidx_next  = hidx_p1;
            state_next = S_EMIT_RD;
          end
        end
      end
      S_MAX_RD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = S_MAX_OUT;
      end
      S_MAX_OUT: begin
        res_valid   = 1'b1;
        res.element = (cnt != '0) ? rdata : '0;
        res.entries = ENT_W'(cnt);
        res.status  = stat;
        res.last    = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ret  <= ret_next;
    op   <= op_next;
    stat <= stat_next;
    nlim <= nlim_next;
    hidx <= hidx_next;
    pos  <= pos_next;
    cur  <= cur_next;
    lval <= lval_next;
  end

  `MHPQ_ASSERT(a_cnt_bound, cnt <= KW'(CAPACITY))
  `MHPQ_ASSERT(a_port_excl, !(rd_en && wr_en))
  `MHPQ_ASSERT_IMP(a_emit_range, state == S_EMIT_OUT, hidx < cnt)
  `MHPQ_ASSERT_NEXT(a_last_idle, res_valid && res_ready && res.last, state == S_IDLE)

endmodule

/* rtl/core/max_heap_priority_queue.sv */
// Insert sifts up one level at a time, delete sifts down one level at a time,
// and rebuild sifts down each node from the last parent back to the root.
// Sort runs the rebuild, then moves the root into the tail over and over,
// then emits the store word by word; one operation is in flight at a time.
// The single-port store allows one read or one write per cycle.
// Synchronous reset empties the queue; store contents are not cleared.
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_tuser,   // operation
  input  logic [DATA_W-1:0] s_tdata,   // value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // element, entries, status (from bit 0 up)
  output logic              m_tlast    // last
);

  // The engine holds the heap in a synchronous memory and walks it with a
  // small sequencer: sift-up for insert, sift-down for delete, bottom-up
  // heapify for rebuild, and heapify plus repeated root extraction for sort.
  // Sort leaves the store in ascending order and then reads it out word by
  // word. All other operations end with a read of the root to report the
  // current maximum together with the element count.

  req_t    req;
  result_t res, out_res;
  logic    start, eng_idle, res_valid, res_ready;

  assign req.op    = op_t'(s_tuser);
  assign req.value = s_tdata;

  // A new operation is taken whenever the sequencer is idle, even if the
  // previous result word still waits in the output register.
  assign s_tready = eng_idle;
  assign start    = s_tvalid && s_tready;

  mhpq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: it refills in the same cycle the current word leaves.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.status, out_res.entries, out_res.element};
  assign m_tlast = out_res.last;

endmodule
